@@ hw/rtl/assert_macros.svh @@
// Assertion helpers; the assertions compile out when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/ppp_pkg.sv @@
`default_nettype none
package ppp_pkg;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_COEFS = 9;
  localparam int NUM_W  = 50;  // numerator / depth width
  localparam int PROD_W = 82;  // |f| * |num|
  localparam int REM_W  = 84;  // partial remainder width
  localparam int Q_W    = 34;  // quotient bits kept before clamp
  localparam int SPLIT  = 25;  // split point of the wide multiply

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PROJ = 1'b1;

  localparam logic [3:0] C_R00 = 4'd0;
  localparam logic [3:0] C_R01 = 4'd1;
  localparam logic [3:0] C_R10 = 4'd2;
  localparam logic [3:0] C_R11 = 4'd3;
  localparam logic [3:0] C_R20 = 4'd4;
  localparam logic [3:0] C_R21 = 4'd5;
  localparam logic [3:0] C_T0  = 4'd6;
  localparam logic [3:0] C_T1  = 4'd7;
  localparam logic [3:0] C_T2  = 4'd8;

  localparam logic [3:0] REG_FOCAL_X = 4'd0;
  localparam logic [3:0] REG_FOCAL_Y = 4'd1;
  localparam logic [3:0] REG_WIDTH   = 4'd2;
  localparam logic [3:0] REG_HEIGHT  = 4'd3;

  typedef struct packed {
    logic valid;
    logic dz;
  } ctrl_t;

  typedef struct packed {
    logic [PROD_W-1:0] dividend;
    logic [NUM_W-1:0]  divisor;
    logic              neg;
  } lane_t;
endpackage
`default_nettype wire

@@ hw/rtl/ppp_front.sv @@
`default_nettype none
module ppp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 func,
  input  logic [3:0]           coef_index,
  input  logic signed [31:0]   coef_value,
  input  logic signed [31:0]   point_x,
  input  logic signed [31:0]   point_y,
  input  logic signed [31:0]   focal_x,
  input  logic signed [31:0]   focal_y,
  output ppp_pkg::ctrl_t       ctl_out,
  output ppp_pkg::lane_t       lane_x,
  output ppp_pkg::lane_t       lane_y
);
  import ppp_pkg::*;

  logic signed [31:0] pose [0:NUM_COEFS-1];

  // stage A: products
  logic               va;
  logic signed [63:0] pa [0:5];
  logic signed [31:0] ta [0:2];
  // stage B: linear forms
  logic               vb;
  logic signed [NUM_W-1:0] nxb, nyb, db;
  // stage C: magnitudes
  logic               vc, dzc, ngxc, ngyc;
  logic [31:0]        fmx, fmy;
  logic [NUM_W-1:0]   nmx, nmy, dmc;
  // stage D: partial products
  logic               vd, dzd, ngxd, ngyd;
  logic [56:0]        plx, phx, ply, phy;
  logic [NUM_W-1:0]   dmd;
  // stage E: full products
  logic               ve, dze, ngxe, ngye;
  logic [PROD_W-1:0]  px, py;
  logic [NUM_W-1:0]   dme;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) pose[i] <= '0;
    end else if (en && in_valid && func == FUNC_LOAD && coef_index <= C_T2) begin
      pose[coef_index] <= coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else if (en) begin
      va <= in_valid && func == FUNC_PROJ;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= pose[C_R00] * point_x;
      pa[1] <= pose[C_R01] * point_y;
      pa[2] <= pose[C_R10] * point_x;
      pa[3] <= pose[C_R11] * point_y;
      pa[4] <= pose[C_R20] * point_x;
      pa[5] <= pose[C_R21] * point_y;
      ta[0] <= pose[C_T0];
      ta[1] <= pose[C_T1];
      ta[2] <= pose[C_T2];
      // arithmetic shift right is the floor to Q16.16
      nxb <= NUM_W'(pa[0] >>> FRAC_BITS) + NUM_W'(pa[1] >>> FRAC_BITS) + NUM_W'(ta[0]);
      nyb <= NUM_W'(pa[2] >>> FRAC_BITS) + NUM_W'(pa[3] >>> FRAC_BITS) + NUM_W'(ta[1]);
      db  <= NUM_W'(pa[4] >>> FRAC_BITS) + NUM_W'(pa[5] >>> FRAC_BITS) + NUM_W'(ta[2]);

      nmx  <= nxb[NUM_W-1] ? NUM_W'(-nxb) : NUM_W'(nxb);
      nmy  <= nyb[NUM_W-1] ? NUM_W'(-nyb) : NUM_W'(nyb);
      dmc  <= db[NUM_W-1] ? NUM_W'(-db) : NUM_W'(db);
      fmx  <= focal_x[31] ? 32'(-focal_x) : 32'(focal_x);
      fmy  <= focal_y[31] ? 32'(-focal_y) : 32'(focal_y);
      ngxc <= focal_x[31] ^ nxb[NUM_W-1] ^ db[NUM_W-1];
      ngyc <= focal_y[31] ^ nyb[NUM_W-1] ^ db[NUM_W-1];
      dzc  <= (db == '0);

      plx  <= {25'b0, fmx} * {32'b0, nmx[SPLIT-1:0]};
      phx  <= {25'b0, fmx} * {32'b0, nmx[NUM_W-1:SPLIT]};
      ply  <= {25'b0, fmy} * {32'b0, nmy[SPLIT-1:0]};
      phy  <= {25'b0, fmy} * {32'b0, nmy[NUM_W-1:SPLIT]};
      dmd  <= dmc;
      dzd  <= dzc;
      ngxd <= ngxc;
      ngyd <= ngyc;

      px   <= {phx, {SPLIT{1'b0}}} + {{SPLIT{1'b0}}, plx};
      py   <= {phy, {SPLIT{1'b0}}} + {{SPLIT{1'b0}}, ply};
      dme  <= dmd;
      dze  <= dzd;
      ngxe <= ngxd;
      ngye <= ngyd;
    end
  end

  assign ctl_out.valid   = ve;
  assign ctl_out.dz      = dze;
  assign lane_x.dividend = px;
  assign lane_x.divisor  = dme;
  assign lane_x.neg      = ngxe;
  assign lane_y.dividend = py;
  assign lane_y.divisor  = dme;
  assign lane_y.neg      = ngye;
endmodule
`default_nettype wire

@@ hw/rtl/ppp_div.sv @@
`default_nettype none
module ppp_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  ppp_pkg::ctrl_t           ctl_in,
  input  ppp_pkg::lane_t           lane_in,
  output ppp_pkg::ctrl_t           ctl_out,
  output logic [ppp_pkg::Q_W-1:0]  quot,
  output logic                     neg_out
);
  import ppp_pkg::*;

  logic [REM_W-1:0] rem [0:Q_W];
  logic [Q_W-1:0]   qs  [0:Q_W];
  logic [NUM_W-1:0] dv  [0:Q_W];
  logic             ng  [0:Q_W];
  logic             ov  [0:Q_W];
  ctrl_t            ct  [0:Q_W];

  // stage 0: quotient too large for Q_W bits -> clamp at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      ct[0] <= '0;
    end else if (en) begin
      ct[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= REM_W'(lane_in.dividend);
      ov[0]  <= REM_W'(lane_in.dividend) >= {lane_in.divisor, {Q_W{1'b0}}};
      qs[0]  <= '0;
      dv[0]  <= lane_in.divisor;
      ng[0]  <= lane_in.neg;
    end
  end

  // one restoring step per stage, MSB first
  for (genvar j = 1; j <= Q_W; j++) begin : g_step
    localparam int SH = Q_W - j;
    logic [REM_W:0] trial;
    assign trial = {1'b0, rem[j-1]} - {1'b0, (REM_W'(dv[j-1]) << SH)};

    always_ff @(posedge clk) begin
      if (rst) begin
        ct[j] <= '0;
      end else if (en) begin
        ct[j] <= ct[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= trial[REM_W] ? rem[j-1] : trial[REM_W-1:0];
        qs[j]  <= {qs[j-1][Q_W-2:0], ~trial[REM_W]};
        dv[j]  <= dv[j-1];
        ng[j]  <= ng[j-1];
        ov[j]  <= ov[j-1];
      end
    end
  end

  assign ctl_out = ct[Q_W];
  assign quot    = ov[Q_W] ? {Q_W{1'b1}} : qs[Q_W];
  assign neg_out = ng[Q_W];
endmodule
`default_nettype wire

@@ hw/rtl/ppp_out.sv @@
`default_nettype none
module ppp_out #(
  parameter int VALUE_WIDTH = ppp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  ppp_pkg::ctrl_t          ctl,
  input  logic [ppp_pkg::Q_W-1:0] qx,
  input  logic [ppp_pkg::Q_W-1:0] qy,
  input  logic                    negx,
  input  logic                    negy,
  input  logic [15:0]             image_width,
  input  logic [15:0]             image_height,
  output logic                    out_valid,
  output logic signed [31:0]      pixel_x,
  output logic signed [31:0]      pixel_y,
  output logic                    depth_zero,
  output logic                    saturated
);
  import ppp_pkg::*;

  localparam int CW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
  localparam int SW = Q_W + 3;
  localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  // {clamped, value}
  function automatic logic [32:0] place(input logic [Q_W-1:0] q, input logic neg,
                                        input logic [15:0] size);
    logic signed [SW-1:0] sq;
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] c;
    c  = SW'({1'b0, size[15:1], {FRAC_BITS{1'b0}}});
    sq = neg ? -SW'(q) : SW'(q);
    v  = sq + c;
    if (v > MAXV) place = {1'b1, 32'(MAXV)};
    else if (v < MINV) place = {1'b1, 32'(MINV)};
    else place = {1'b0, 32'(v)};
  endfunction

  logic [32:0] rx, ry;
  assign rx = place(qx, negx, image_width);
  assign ry = place(qy, negy, image_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth_zero <= ctl.dz;
      pixel_x    <= ctl.dz ? '0 : $signed(rx[31:0]);
      pixel_y    <= ctl.dz ? '0 : $signed(ry[31:0]);
      saturated  <= ~ctl.dz & (rx[32] | ry[32]);
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/planar_point_perspective_projection.sv @@
// Planar pinhole projection, Q16.16, one transfer per clock in and out while out_ready keeps the pipe moving.
// Pipeline: 5 front stages, 35 divider stages and 1 output register between input
// transfer and result; throughput one item per cycle while the result channel is
// not stalled, set by the one-bit-per-stage pipelined divider. Coefficient loads take effect at once.
// Reset (synchronous, rst high): pose cleared, focal 0, image 640x480, pipe empty.
`default_nettype none
`include "assert_macros.svh"
module planar_point_perspective_projection #(
  parameter int VALUE_WIDTH = ppp_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // config write port
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pixel_x,
  output logic signed [31:0] pixel_y,
  output logic               depth_zero,
  output logic               saturated
);
  import ppp_pkg::*;

  logic signed [31:0] focal_x, focal_y;
  logic [15:0]        image_width, image_height;

  // whole pipe moves when the output register is free or being drained
  logic en;
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= '0;
      focal_y      <= '0;
      image_width  <= 16'd640;
      image_height <= 16'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL_X: focal_x      <= cfg_data;
        REG_FOCAL_Y: focal_y      <= cfg_data;
        REG_WIDTH:   image_width  <= cfg_data[15:0];
        REG_HEIGHT:  image_height <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ctrl_t ctl_f, ctl_x, ctl_y;
  lane_t lane_x, lane_y;
  logic [Q_W-1:0] qx, qy;
  logic negx, negy;

  ppp_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .func(func), .coef_index(coef_index),
    .coef_value(coef_value), .point_x(point_x), .point_y(point_y),
    .focal_x(focal_x), .focal_y(focal_y),
    .ctl_out(ctl_f), .lane_x(lane_x), .lane_y(lane_y)
  );

  ppp_div u_div_x (
    .clk(clk), .rst(rst), .en(en), .ctl_in(ctl_f), .lane_in(lane_x),
    .ctl_out(ctl_x), .quot(qx), .neg_out(negx)
  );

  ppp_div u_div_y (
    .clk(clk), .rst(rst), .en(en), .ctl_in(ctl_f), .lane_in(lane_y),
    .ctl_out(ctl_y), .quot(qy), .neg_out(negy)
  );

  ppp_out #(.VALUE_WIDTH(VALUE_WIDTH)) u_out (
    .clk(clk), .rst(rst), .en(en), .ctl(ctl_x),
    .qx(qx), .qy(qy), .negx(negx), .negy(negy),
    .image_width(image_width), .image_height(image_height),
    .out_valid(out_valid), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .depth_zero(depth_zero), .saturated(saturated)
  );

  // both divider lanes must stay in lock step
  `ASSERT_IMPL(a_lane_valid, 1'b1, ctl_x.valid == ctl_y.valid)
  `ASSERT_IMPL(a_lane_dz, ctl_x.valid, ctl_x.dz == ctl_y.dz)
  // a zero depth result carries zero pixels and no clamp flag
  `ASSERT_IMPL(a_dz_out, out_valid && depth_zero,
               pixel_x == 32'sd0 && pixel_y == 32'sd0 && !saturated)
  // while a result is stalled, the divider's output control ctl_x stays stable
  `ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, $stable(ctl_x))
endmodule
`default_nettype wire
